// ===== rtl/rth_pkg.sv =====
// Shared types and constants for the integer RGB to HSV converter.
package rth_pkg;

  // Quotient bits produced by the division chain (the hue fraction reaches 65536).
  localparam int unsigned QuotBits  = 17;
  localparam int unsigned FracShift = 16;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned HueW      = 19;
  localparam int unsigned SatW      = 16;

  // Hue sector, selected from the positions of the maximum and minimum channel.
  typedef enum logic [2:0] {
    SecRedMaxBlueMin   = 3'd0,
    SecGreenMaxBlueMin = 3'd1,
    SecGreenMaxRedMin  = 3'd2,
    SecBlueMaxRedMin   = 3'd3,
    SecBlueMaxGreenMin = 3'd4,
    SecOther           = 3'd5
  } rth_sector_e;

  // One restoring division in flight: partial remainder, divisor, and a shift
  // register that feeds numerator bits out of the top and takes quotient bits in.
  typedef struct packed {
    logic [ChanW-1:0]    rem;
    logic [ChanW-1:0]    div;
    logic [QuotBits-1:0] num;
  } rth_div_t;

  // Everything one pixel carries along the chain.
  typedef struct packed {
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] alpha;
    logic             grey;
    rth_sector_e      sector;
    rth_div_t         sat;
    rth_div_t         frac;
  } rth_stage_t;

endpackage

// ===== rtl/rth_prep.sv =====
// Front stage: max, min, median, sector choice and division set-up for one pixel.
module rth_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [rth_pkg::ChanW-1:0]     red_i,
  input  logic [rth_pkg::ChanW-1:0]     green_i,
  input  logic [rth_pkg::ChanW-1:0]     blue_i,
  input  logic [rth_pkg::ChanW-1:0]     alpha_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output rth_pkg::rth_stage_t           data_o
);

  logic                        valid_q;
  rth_pkg::rth_stage_t         data_q, data_d;
  logic [rth_pkg::ChanW-1:0]   mx, mn, med, span, span_m1, med_off;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;

    // Median as the model picks it, ties included.
    if ((red_i > green_i) != (red_i > blue_i)) begin
      med = red_i;
    end else if ((green_i < red_i) != (green_i < blue_i)) begin
      med = green_i;
    end else begin
      med = blue_i;
    end

    span    = mx - mn;
    span_m1 = span - 8'd1;
    med_off = med - mn;

    data_d.value = mx;
    data_d.alpha = alpha_i;
    data_d.grey  = (span == '0);

    if (mx == red_i && mn == blue_i) begin
      data_d.sector = rth_pkg::SecRedMaxBlueMin;
    end else if (mx == green_i && mn == blue_i) begin
      data_d.sector = rth_pkg::SecGreenMaxBlueMin;
    end else if (mx == green_i && mn == red_i) begin
      data_d.sector = rth_pkg::SecGreenMaxRedMin;
    end else if (mx == blue_i && mn == red_i) begin
      data_d.sector = rth_pkg::SecBlueMaxRedMin;
    end else if (mx == blue_i && mn == green_i) begin
      data_d.sector = rth_pkg::SecBlueMaxGreenMin;
    end else begin
      data_d.sector = rth_pkg::SecOther;
    end

    // Saturation numerator is span*65536-1 = {span-1, 16 ones}; its top seven
    // bits are already below the divisor, so they seed the remainder.
    data_d.sat.rem = {1'b0, span_m1[7:1]};
    data_d.sat.div = mx;
    data_d.sat.num = {span_m1[0], {rth_pkg::FracShift{1'b1}}};

    // Fraction numerator is (median-min)*65536, seeded the same way.
    data_d.frac.rem = {1'b0, med_off[7:1]};
    data_d.frac.div = span;
    data_d.frac.num = {med_off[0], {rth_pkg::FracShift{1'b0}}};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rth_div_cell.sv =====
// One cell of the division chain: one restoring step for both divisions.
module rth_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rth_pkg::rth_stage_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rth_pkg::rth_stage_t data_o
);

  logic                valid_q;
  rth_pkg::rth_stage_t data_q, data_d;
  logic [8:0]          sat_trial, frac_trial;
  logic                sat_ge, frac_ge;

  always_comb begin
    data_d = data_i;

    sat_trial = {data_i.sat.rem, data_i.sat.num[rth_pkg::QuotBits-1]};
    sat_ge    = (sat_trial >= {1'b0, data_i.sat.div});
    data_d.sat.rem = sat_ge ? 8'(sat_trial - {1'b0, data_i.sat.div}) : sat_trial[7:0];
    data_d.sat.num = {data_i.sat.num[rth_pkg::QuotBits-2:0], sat_ge};

    frac_trial = {data_i.frac.rem, data_i.frac.num[rth_pkg::QuotBits-1]};
    frac_ge    = (frac_trial >= {1'b0, data_i.frac.div});
    data_d.frac.rem = frac_ge ? 8'(frac_trial - {1'b0, data_i.frac.div}) : frac_trial[7:0];
    data_d.frac.num = {data_i.frac.num[rth_pkg::QuotBits-2:0], frac_ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rth_finish.sv =====
// Output stage: assembles hue and saturation from the quotients and holds the result.
module rth_finish (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  rth_pkg::rth_stage_t       data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [rth_pkg::HueW-1:0]  hue_o,
  output logic [rth_pkg::SatW-1:0]  saturation_o,
  output logic [rth_pkg::ChanW-1:0] value_o,
  output logic [rth_pkg::ChanW-1:0] alpha_o
);

  logic                      valid_q;
  logic [rth_pkg::HueW-1:0]  hue_q, hue_d;
  logic [rth_pkg::SatW-1:0]  sat_q, sat_d;
  logic [rth_pkg::ChanW-1:0] value_q, alpha_q;
  logic [19:0]               base, frac;

  always_comb begin
    // sector * 65535 without a multiplier.
    base = {1'b0, data_i.sector, 16'b0} - 20'(data_i.sector);
    // Odd sectors mirror the fraction: 65535 - (q + 1); may dip below zero
    // when the median ties the maximum, which wraps exactly as the 19-bit mask does.
    if (data_i.sector[0]) begin
      frac = 20'd65534 - 20'(data_i.frac.num);
    end else begin
      frac = 20'(data_i.frac.num) + 20'd1;
    end
    if (data_i.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = rth_pkg::HueW'(base + frac);
      sat_d = data_i.sat.num[rth_pkg::SatW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= data_i.value;
      alpha_q <= data_i.alpha;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;
  assign alpha_o      = alpha_q;

endmodule

// ===== rtl/rgb_to_hsv_integer.sv =====
// Top level of the integer RGB to HSV converter with a 16-bit-per-sector hue.
//
// One RGBA pixel enters on the slave stream and one HSV pixel leaves on the
// master stream for every item, in order. The block has no configuration.
// Structure: a set-up stage finds max, min, median and the hue sector, then a
// row of 17 identical division cells each works out one quotient bit of both
// the saturation and the hue fraction divisions, and an output register
// forms the hue and holds the result.
// Throughput is one item per clock while the receiver is ready: every stage
// then passes its item on in each cycle, so a new pixel can be accepted
// every cycle.
// Each stage takes a new item whenever it is empty or its neighbour takes
// its current one, so when the receiver stalls the items close up behind
// the output register and the slave side keeps accepting until the chain
// is full; tready then drops. Reset (rst_ni low, asynchronous) empties
// every stage; no item is lost or repeated across a stall.
module rgb_to_hsv_integer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // hue [18:0], saturation [34:19], value [42:35],
                                     // alpha_out [50:43], zeros [55:51]
);

  localparam int unsigned NumCells = rth_pkg::QuotBits;

  // Chain links: index 0 is the set-up stage output, index NumCells the last cell.
  logic                valid_c [NumCells+1];
  logic                ready_c [NumCells+1];
  rth_pkg::rth_stage_t data_c  [NumCells+1];

  logic [rth_pkg::HueW-1:0]  hue;
  logic [rth_pkg::SatW-1:0]  saturation;
  logic [rth_pkg::ChanW-1:0] value, alpha_out;

  rth_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .alpha_i (s_axis_tdata[31:24]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .data_o  (data_c[0])
  );

  // One quotient bit per cell, most significant first.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  rth_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_c[NumCells]),
    .ready_o      (ready_c[NumCells]),
    .data_i       (data_c[NumCells]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .hue_o        (hue),
    .saturation_o (saturation),
    .value_o      (value),
    .alpha_o      (alpha_out)
  );

  assign m_axis_tdata = {5'b0, alpha_out, value, saturation, hue};

endmodule

// ===== tb/rth_checker.sv =====
// Checker for the RGB to HSV converter: predicts each HSV item and compares it with the block.
module rth_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rth_pkg::HueW-1:0]  hue;
    logic [rth_pkg::SatW-1:0]  sat;
    logic [rth_pkg::ChanW-1:0] value;
    logic [rth_pkg::ChanW-1:0] alpha;
  } hsv_pixel_t;

  hsv_pixel_t hsv_expected_q[$];
  int         fails;

  // Works out the HSV item for one RGBA pixel (red in the lowest byte).
  function automatic hsv_pixel_t predict_hsv(input logic [31:0] px);
    logic [rth_pkg::ChanW-1:0] r, g, b, hi, lo, mid;
    logic [31:0]               span, offset, quot;
    rth_pkg::rth_sector_e      sec;
    int                        frac;
    int                        h;
    hsv_pixel_t                res;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    // The median goes to the first channel that lies between the other two.
    if ((r > g) != (r > b)) begin
      mid = r;
    end else if ((g < r) != (g < b)) begin
      mid = g;
    end else begin
      mid = b;
    end
    span = 32'(hi) - 32'(lo);
    res.value = hi;
    res.alpha = px[31:24];
    res.hue   = '0;
    res.sat   = '0;
    if (span != 0) begin
      quot    = ((span << rth_pkg::FracShift) - 32'd1) / 32'(hi);
      res.sat = quot[rth_pkg::SatW-1:0];
      if (hi == r && lo == b) begin
        sec = rth_pkg::SecRedMaxBlueMin;
      end else if (hi == g && lo == b) begin
        sec = rth_pkg::SecGreenMaxBlueMin;
      end else if (hi == g && lo == r) begin
        sec = rth_pkg::SecGreenMaxRedMin;
      end else if (hi == b && lo == r) begin
        sec = rth_pkg::SecBlueMaxRedMin;
      end else if (hi == b && lo == g) begin
        sec = rth_pkg::SecBlueMaxGreenMin;
      end else begin
        sec = rth_pkg::SecOther;
      end
      offset = 32'(mid) - 32'(lo);
      quot   = (offset << rth_pkg::FracShift) / span;
      frac   = int'(quot) + 1;
      // Odd sectors run backwards; a median equal to the maximum overshoots on purpose.
      if (sec[0]) frac = 65535 - frac;
      h       = 65535 * int'(sec) + frac;
      res.hue = h[rth_pkg::HueW-1:0];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hsv_pixel_t want;
    hsv_pixel_t got;
    if (!rst_ni) begin
      hsv_expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.hue   = m_tdata_i[18:0];
        got.sat   = m_tdata_i[34:19];
        got.value = m_tdata_i[42:35];
        got.alpha = m_tdata_i[50:43];
        if (hsv_expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual 0x%014h", $time, m_tdata_i);
          fails++;
        end else begin
          want = hsv_expected_q.pop_front();
          check_field("hue", want.hue, got.hue);
          check_field("saturation", want.sat, got.sat);
          check_field("value", want.value, got.value);
          check_field("alpha_out", want.alpha, got.alpha);
          check_field("padding", 0, m_tdata_i[55:51]);
        end
      end
      if (s_tvalid_i && s_tready_i) hsv_expected_q.push_back(predict_hsv(s_tdata_i));
      fail_count_o <= fails + hsv_expected_q.size() * 0;
      pending_o    <= hsv_expected_q.size();
    end
  end

endmodule

// ===== tb/tb_rgb_to_hsv_integer.sv =====
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
module tb_rgb_to_hsv_integer;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted item before the run is declared hung. The
  // longest quiet stretch is the receiver's deliberate hold-off.
  localparam int StallLimit  = 3000;
  // Latency of the block from acceptance to the result, used for the final wait.
  localparam int PipeLatency = 18;
  localparam int RandomItems = 1250;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // hue [18:0], saturation [34:19], value [42:35],
                               // alpha_out [50:43], zeros [55:51]
  int          fail_count;
  int          pending;
  int          idle_cycles;

  rgb_to_hsv_integer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rth_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The watchdog restarts its count whenever either side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_rgb_to_hsv_integer: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] make_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a);
    return {a, b, g, r};
  endfunction

  // Random pixels lean towards the awkward cases: ties, greys, narrow spans
  // and channels pinned to the ends of their range.
  function automatic logic [31:0] random_pixel();
    logic [7:0] r, g, b, v, base;
    int         kind;
    kind = $urandom_range(0, 99);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if (kind >= 55 && kind < 70) begin
      v = 8'($urandom);
      case ($urandom_range(0, 2))
        0: begin
          r = v;
          g = v;
        end
        1: begin
          g = v;
          b = v;
        end
        default: begin
          r = v;
          b = v;
        end
      endcase
    end else if (kind >= 70 && kind < 78) begin
      g = r;
      b = r;
    end else if (kind >= 78 && kind < 90) begin
      base = 8'($urandom_range(0, 252));
      r = base + 8'($urandom_range(0, 3));
      g = base + 8'($urandom_range(0, 3));
      b = base + 8'($urandom_range(0, 3));
    end else if (kind >= 90) begin
      if ($urandom_range(0, 2) == 0) r = '0; else if ($urandom_range(0, 1) == 0) r = '1;
      if ($urandom_range(0, 2) == 0) g = '0; else if ($urandom_range(0, 1) == 0) g = '1;
      if ($urandom_range(0, 2) == 0) b = '0; else if ($urandom_range(0, 1) == 0) b = '1;
    end
    return make_pixel(r, g, b, 8'($urandom));
  endfunction

  // Offers one item and returns at the edge where it is taken; valid stays
  // high so that a following item can go out back to back.
  task automatic offer_pixel(input logic [31:0] px);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: short random stalls, quiet stretches with none, and two long
  // hold-offs during which the sender keeps offering so the chain fills up.
  initial begin
    int taken;
    int stall_left;
    int pick;
    taken         = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        taken++;
        if (taken == 150 || taken == 800) stall_left = 400;
      end
      if (stall_left == 0 && rst_ni && ((taken / 200) % 3 != 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          stall_left = $urandom_range(1, 3);
        end else if (pick < 23) begin
          stall_left = $urandom_range(10, 50);
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] directed_q[$];
    int          pick;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Black, white and a grey give zero hue and saturation.
    directed_q.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0));
    directed_q.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    directed_q.push_back(make_pixel(8'd77, 8'd77, 8'd77, 8'h55));
    // Primaries and secondaries land on sector boundaries.
    directed_q.push_back(make_pixel(8'd255, 8'd0, 8'd0, 8'hAA));
    directed_q.push_back(make_pixel(8'd0, 8'd255, 8'd0, 8'd1));
    directed_q.push_back(make_pixel(8'd0, 8'd0, 8'd255, 8'd128));
    directed_q.push_back(make_pixel(8'd0, 8'd255, 8'd255, 8'd254));
    directed_q.push_back(make_pixel(8'd255, 8'd0, 8'd255, 8'd7));
    // Maximum tied with the median: the fraction overshoots the sector end.
    directed_q.push_back(make_pixel(8'd255, 8'd255, 8'd0, 8'd200));
    directed_q.push_back(make_pixel(8'd30, 8'd200, 8'd200, 8'd9));
    directed_q.push_back(make_pixel(8'd180, 8'd40, 8'd180, 8'd60));
    // Minimum tied with the median.
    directed_q.push_back(make_pixel(8'd200, 8'd50, 8'd50, 8'd3));
    directed_q.push_back(make_pixel(8'd10, 8'd90, 8'd10, 8'd4));
    directed_q.push_back(make_pixel(8'd60, 8'd60, 8'd250, 8'd5));
    // One pixel strictly inside each of the six sectors.
    directed_q.push_back(make_pixel(8'd200, 8'd100, 8'd20, 8'd11));
    directed_q.push_back(make_pixel(8'd150, 8'd220, 8'd30, 8'd12));
    directed_q.push_back(make_pixel(8'd15, 8'd240, 8'd130, 8'd13));
    directed_q.push_back(make_pixel(8'd5, 8'd120, 8'd230, 8'd14));
    directed_q.push_back(make_pixel(8'd140, 8'd25, 8'd210, 8'd15));
    directed_q.push_back(make_pixel(8'd250, 8'd2, 8'd100, 8'd16));
    // Smallest spans, at the bottom and the top of the range.
    directed_q.push_back(make_pixel(8'd1, 8'd0, 8'd0, 8'd17));
    directed_q.push_back(make_pixel(8'd255, 8'd254, 8'd254, 8'd18));
    directed_q.push_back(make_pixel(8'd254, 8'd255, 8'd253, 8'd19));

    foreach (directed_q[k]) offer_pixel(directed_q[k]);
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 600) drain_results();
      // Every third stretch of 150 items goes out with no gaps at all.
      if ((n / 150) % 3 != 2) begin
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 90) begin
          idle_sender($urandom_range(1, 3));
        end else if (pick >= 90) begin
          idle_sender($urandom_range(8, 40));
        end
      end
      offer_pixel(random_pixel());
    end

    drain_results();
    repeat (3 * PipeLatency) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rgb_to_hsv_integer: done, clean");
    end else begin
      $display("tb_rgb_to_hsv_integer: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rth_pkg.sv
rtl/rth_prep.sv
rtl/rth_div_cell.sv
rtl/rth_finish.sv
rtl/rgb_to_hsv_integer.sv
tb/rth_checker.sv
tb/tb_rgb_to_hsv_integer.sv
